// File: design/lzfg_pkg.sv
// Shared constants and command type for the LZSS flag-group decompressor.
package lzfg_pkg;

  localparam int unsigned HIST_DEPTH   = 4096;
  localparam int unsigned HIST_AW      = $clog2(HIST_DEPTH);
  localparam int unsigned DIST_W       = 12;
  localparam int unsigned COUNT_W      = 12;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned LEN_BIAS     = 3;
  localparam int unsigned LEN_CODE_MSK = 'h0F;
  localparam int unsigned GROUP_TOKENS = 8;
  localparam int unsigned TOK_W        = 4;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_LIT  = 1'b0,
    CMD_COPY = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        lit;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

// File: design/lzfg_front.sv
// Parser: accepts compressed bytes, tracks group flags and emits literal/copy commands.
module lzfg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_stream_i,
  input  logic           fifo_full_i,
  output logic           push_o,
  output lzfg_pkg::cmd_t cmd_o
);

  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]                     phase_q, phase_d;
  logic [7:0]                     flags_q, flags_d;
  logic [lzfg_pkg::TOK_W-1:0]     tok_q, tok_d;
  logic [7:0]                     hi_q, hi_d;
  logic [lzfg_pkg::COUNT_W-1:0]   count_q, count_d;

  logic                           accept;
  logic [lzfg_pkg::DIST_W-1:0]    raw_dist;
  logic [lzfg_pkg::DIST_W-1:0]    clamp_dist;
  logic [lzfg_pkg::LEN_W-1:0]     len;
  logic [lzfg_pkg::COUNT_W:0]     count_sum;
  logic [lzfg_pkg::LEN_W-1:0]     add_amt;
  logic [lzfg_pkg::TOK_W-1:0]     tok_inc;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign raw_dist   = {hi_q, in_byte_i[7:lzfg_pkg::NIBBLE_W]};
  assign clamp_dist = (raw_dist > count_q) ? count_q : raw_dist;
  assign len        = lzfg_pkg::LEN_W'(in_byte_i & 8'(lzfg_pkg::LEN_CODE_MSK))
                      + lzfg_pkg::LEN_W'(lzfg_pkg::LEN_BIAS);
  assign count_sum  = {1'b0, count_q} + (lzfg_pkg::COUNT_W+1)'(add_amt);
  assign tok_inc    = tok_q + lzfg_pkg::TOK_W'(1);

  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    tok_d   = tok_q;
    hi_d    = hi_q;
    count_d = count_q;
    push_o  = 1'b0;
    add_amt = '0;
    cmd_o.kind     = lzfg_pkg::CMD_LIT;
    cmd_o.lit      = in_byte_i;
    cmd_o.distance = clamp_dist;
    cmd_o.len      = len;
    if (accept) begin
      case (phase_q)
        PH_TOKEN: begin
          if (flags_q[tok_q[2:0]]) begin
            // First byte of a reference; drop it when the stream ends here.
            if (!end_of_stream_i) begin
              hi_d    = in_byte_i;
              phase_d = PH_SECOND;
            end
          end else begin
            push_o  = 1'b1;
            add_amt = lzfg_pkg::LEN_W'(1);
            tok_d   = tok_inc;
            if (tok_inc >= lzfg_pkg::TOK_W'(lzfg_pkg::GROUP_TOKENS)) begin
              tok_d   = '0;
              phase_d = PH_FLAG;
            end
          end
        end
        PH_SECOND: begin
          cmd_o.kind = lzfg_pkg::CMD_COPY;
          if (clamp_dist != '0) begin
            push_o  = 1'b1;
            add_amt = len;
          end
          phase_d = PH_TOKEN;
          tok_d   = tok_inc;
          if (tok_inc >= lzfg_pkg::TOK_W'(lzfg_pkg::GROUP_TOKENS)) begin
            tok_d   = '0;
            phase_d = PH_FLAG;
          end
        end
        default: begin
          flags_d = in_byte_i;
          tok_d   = '0;
          phase_d = PH_TOKEN;
        end
      endcase
      // Saturate the produced count.
      if (count_sum > (lzfg_pkg::COUNT_W+1)'(lzfg_pkg::COUNT_MAX)) begin
        count_d = lzfg_pkg::COUNT_MAX;
      end else begin
        count_d = count_sum[lzfg_pkg::COUNT_W-1:0];
      end
      if (end_of_stream_i) begin
        phase_d = PH_FLAG;
        flags_d = '0;
        tok_d   = '0;
        hi_d    = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      flags_q <= '0;
      tok_q   <= '0;
      hi_q    <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      tok_q   <= tok_d;
      hi_q    <= hi_d;
      count_q <= count_d;
    end
  end

endmodule

// File: design/lzfg_cmd_fifo.sv
// Small command queue between the parser and the copy engine.
module lzfg_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzfg_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lzfg_pkg::cmd_t cmd_o
);

  lzfg_pkg::cmd_t                 mem_q [lzfg_pkg::FIFO_DEPTH];
  logic [lzfg_pkg::FIFO_AW-1:0]   wr_q, rd_q;
  logic [lzfg_pkg::FIFO_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (lzfg_pkg::FIFO_AW+1)'(lzfg_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + lzfg_pkg::FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + lzfg_pkg::FIFO_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (lzfg_pkg::FIFO_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (lzfg_pkg::FIFO_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: design/lzfg_back.sv
// Copy engine: history ring, literal writes and back-reference copies, output register.
module lzfg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lzfg_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o
);

  logic [7:0] ring_mem [lzfg_pkg::HIST_DEPTH];

  logic [lzfg_pkg::HIST_AW-1:0] wp_q, wp_d;
  logic [lzfg_pkg::HIST_AW-1:0] rp_q, rp_d;
  logic [lzfg_pkg::LEN_W-1:0]   rem_q, rem_d;
  logic                         pend_q, pend_d;
  logic                         ov_q, ov_d;
  logic [7:0]                   ob_q, ob_d;
  logic                         ol_q, ol_d;

  logic [7:0]                   rdata_q, byp_data_q;
  logic                         byp_q;

  logic                         adv, lit_go, copy_go, emit_copy;
  logic                         we, re;
  logic [lzfg_pkg::HIST_AW-1:0] raddr, copy_start;
  logic [7:0]                   wdata, rd_value;

  assign adv        = !ov_q || out_ready_i;
  assign cmd_pop_o  = adv && !pend_q && cmd_valid_i;
  assign lit_go     = cmd_pop_o && (cmd_i.kind == lzfg_pkg::CMD_LIT);
  assign copy_go    = cmd_pop_o && (cmd_i.kind == lzfg_pkg::CMD_COPY);
  assign emit_copy  = adv && pend_q;
  assign copy_start = wp_q - lzfg_pkg::HIST_AW'(cmd_i.distance);
  assign rd_value   = byp_q ? byp_data_q : rdata_q;

  assign we    = lit_go || emit_copy;
  assign wdata = lit_go ? cmd_i.lit : rd_value;
  assign re    = copy_go || (emit_copy && (rem_q != '0));
  assign raddr = copy_go ? copy_start : rp_q;

  // Ring port; a read of the entry written in the same cycle takes the write data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[wp_q] <= wdata;
    end
    if (re) begin
      rdata_q    <= ring_mem[raddr];
      byp_q      <= we && (wp_q == raddr);
      byp_data_q <= wdata;
    end
  end

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    rem_d  = rem_q;
    pend_d = pend_q;
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    if (copy_go) begin
      rp_d   = copy_start + lzfg_pkg::HIST_AW'(1);
      rem_d  = cmd_i.len - lzfg_pkg::LEN_W'(1);
      pend_d = 1'b1;
    end
    if (emit_copy) begin
      if (rem_q != '0) begin
        rp_d  = rp_q + lzfg_pkg::HIST_AW'(1);
        rem_d = rem_q - lzfg_pkg::LEN_W'(1);
      end else begin
        pend_d = 1'b0;
      end
    end
    if (we) begin
      wp_d = wp_q + lzfg_pkg::HIST_AW'(1);
      ov_d = 1'b1;
      ob_d = wdata;
      ol_d = lit_go || (rem_q == '0);
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      rem_q  <= '0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      rem_q  <= rem_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign last_of_run_o = ol_q;

endmodule

// File: design/lzfg_flag_group_decompressor_top_placeholder.sv
// Registered status check helper: flags a queue push while the queue is full.
module lzfg_push_guard (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic full_i,
  output logic overrun_o
);

  logic overrun_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overrun_q <= 1'b0;
    end else begin
      overrun_q <= overrun_q || (push_i && full_i);
    end
  end

  assign overrun_o = overrun_q;

endmodule

// File: design/lzss_flag_group_decompressor.sv
// LZSS flag-group decompressor: a literal goes from the queue head into the output register;
// a reference first loads the ring read register, then emits one byte per cycle through the
// single ring read port while the output is not stalled, taking no new command until done.
// Input is taken while the four-entry command queue has room.
// Reset (rst_ni low, asynchronous) clears parser, queue and engine control;
// the 4096-byte history ring is not cleared and needs no clearing pass.
module lzss_flag_group_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  // Commands from the parser: a literal byte, or a clamped distance and length.
  logic           push, fifo_full, cmd_valid, cmd_pop, overrun;
  lzfg_pkg::cmd_t push_cmd, head_cmd;

  // Front: classify each item into at most one command.
  lzfg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Queue: decouple parsing from the copy engine, which emits a byte per cycle unless the output stalls.
  lzfg_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (cmd_pop),
    .full_o  (fifo_full),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  // Back: write literals and copied bytes into the ring and the output register.
  lzfg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // Sticky overrun flag for the queue; it must never set.
  lzfg_push_guard u_guard (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (fifo_full),
    .overrun_o (overrun)
  );

  // The parser never pushes into a full queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !overrun)
    else $error("command queue overrun");

  // A popped literal shows up as a single, final byte in the next cycle.
  a_lit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop && (head_cmd.kind == lzfg_pkg::CMD_LIT) |=> out_valid_o && last_of_run_o)
    else $error("literal not presented after pop");

  // Starting a copy only issues the ring read, so the output is empty next cycle.
  a_copy_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop && (head_cmd.kind == lzfg_pkg::CMD_COPY) |=> !out_valid_o)
    else $error("output valid during copy start");

  // A copy is never popped with a zero distance or a short length.
  a_copy_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop && (head_cmd.kind == lzfg_pkg::CMD_COPY) |->
      (head_cmd.distance != '0) &&
      (head_cmd.len >= lzfg_pkg::LEN_W'(lzfg_pkg::LEN_BIAS)))
    else $error("malformed copy command");

endmodule
